// ===== sv/configurable_crc32_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// CRC-32 engine assertion macros
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONFIGURABLE_CRC32_ENGINE_UNIT_ASSERT_SVH
`define CONFIGURABLE_CRC32_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define CCRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ccrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccrc_pkg
// Shared types, register codes and bit-reversal helpers for the CRC-32 engine.
// ----------------------------------------------------------------------------
package ccrc_pkg;

	localparam int unsigned CRC_W      = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [CRC_W-1:0]  POLY_RST  = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0]  INIT_RST  = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0]  XOR_RST   = 32'h0000_0000;
	localparam logic [BYTE_W-1:0] FILL_RST  = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY        = 3'd0,
		REG_INIT        = 3'd1,
		REG_REFLECT_IN  = 3'd2,
		REG_REFLECT_OUT = 3'd3,
		REG_FINAL_XOR   = 3'd4,
		REG_FILL        = 3'd5
	} ccrc_reg_idx_t;

	typedef struct packed {
		logic [CRC_W-1:0]  poly_value;
		logic [CRC_W-1:0]  init_value;
		logic              reflect_in;
		logic              reflect_out;
		logic [CRC_W-1:0]  final_xor;
		logic [BYTE_W-1:0] fill_byte;
	} ccrc_cfg_t;

	function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = v[CRC_W-1-i];
		end
		return r;
	endfunction

endpackage

// ===== sv/ccrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ccrc_cfg_regs
// Configuration register file; one write transaction per cycle, never stalls.
// ----------------------------------------------------------------------------
module ccrc_cfg_regs
	import ccrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data,
	output ccrc_cfg_t            cfg
);

	ccrc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly_value  <= POLY_RST;
			cfg_q.init_value  <= INIT_RST;
			cfg_q.reflect_in  <= 1'b0;
			cfg_q.reflect_out <= 1'b0;
			cfg_q.final_xor   <= XOR_RST;
			cfg_q.fill_byte   <= FILL_RST;
		end else if (cfg_valid) begin
			unique case (ccrc_reg_idx_t'(cfg_index))
				REG_POLY:        cfg_q.poly_value  <= cfg_data;
				REG_INIT:        cfg_q.init_value  <= cfg_data;
				REG_REFLECT_IN:  cfg_q.reflect_in  <= cfg_data[0];
				REG_REFLECT_OUT: cfg_q.reflect_out <= cfg_data[0];
				REG_FINAL_XOR:   cfg_q.final_xor   <= cfg_data;
				REG_FILL:        cfg_q.fill_byte   <= cfg_data[BYTE_W-1:0];
				default: ; // unmapped index: write dropped
			endcase
		end
	end

endmodule

// ===== sv/ccrc_byte_step.sv =====
// ----------------------------------------------------------------------------
// ccrc_byte_step
// One byte of MSB-first CRC update: eight unrolled polynomial steps.
// ----------------------------------------------------------------------------
module ccrc_byte_step
	import ccrc_pkg::*;
(
	input  logic [CRC_W-1:0]  crc_in,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [CRC_W-1:0]  poly,
	output logic [CRC_W-1:0]  crc_out
);

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {byte_in, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
		end
		crc_out = c;
	end

endmodule

// ===== sv/configurable_crc32_engine_unit.sv =====
// ----------------------------------------------------------------------------
// configurable_crc32_engine_unit
// Byte-wide CRC-32 engine with run-time polynomial, init, reflection and XOR.
// ----------------------------------------------------------------------------
// Takes one byte per clock: a byte is registered on entry and folded into the
// CRC register by one eight-step polynomial unit when the stage advances; on a
// tlast byte the finished CRC lands in the output register on that same edge,
// which drives m_tvalid. Throughput is one byte per cycle for as long as the
// result side keeps up; only a tlast byte meeting a stalled, still-full output
// register holds the input side. tuser[1] (restart) reloads init_value before
// the byte, tuser[0] substitutes the fill byte. Configuration writes are always
// accepted and should be made while no byte is in flight.
module configurable_crc32_engine_unit
	import ccrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// byte stream in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic [1:0]           s_tuser,   // [0] use_fill, [1] restart
	input  logic                 s_tlast,   // is_last
	// result out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [31:0] crc_value
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data
);

	ccrc_cfg_t cfg;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              use_fill_s1;
	logic              restart_s1;
	logic              is_last_s1;

	logic [CRC_W-1:0]  crc_q;
	logic              out_valid_q;
	logic [CRC_W-1:0]  out_data_q;

	logic              out_free;
	logic              advance;
	logic [CRC_W-1:0]  crc_base;
	logic [BYTE_W-1:0] feed_byte;
	logic [BYTE_W-1:0] feed_sel;
	logic [CRC_W-1:0]  crc_next;
	logic [CRC_W-1:0]  crc_emit;

	ccrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a tlast byte needs room in the output register before it can retire
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!is_last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1     <= s_tdata;
			use_fill_s1 <= s_tuser[0];
			restart_s1  <= s_tuser[1];
			is_last_s1  <= s_tlast;
		end
	end

	assign crc_base  = restart_s1 ? cfg.init_value : crc_q;
	assign feed_sel  = use_fill_s1 ? cfg.fill_byte : byte_s1;
	assign feed_byte = cfg.reflect_in ? rev8(feed_sel) : feed_sel;

	ccrc_byte_step u_step (
		.crc_in  (crc_base),
		.byte_in (feed_byte),
		.poly    (cfg.poly_value),
		.crc_out (crc_next)
	);

	// output reflection and final XOR touch only the emitted value, never the running register
	assign crc_emit = (cfg.reflect_out ? rev32(crc_next) : crc_next) ^ cfg.final_xor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= INIT_RST;
		end else if (advance) begin
			crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last_s1) begin
			out_data_q <= crc_emit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`include "configurable_crc32_engine_unit_assert.svh"

	`CCRC_ASSERT_NEXT(a_last_emits, advance && is_last_s1, m_tvalid, "tlast byte retired without result")
	`CCRC_ASSERT_NEXT(a_no_spurious, !m_tvalid && !(advance && is_last_s1), !m_tvalid, "result without tlast byte")
	`CCRC_ASSERT_NEXT(a_crc_holds, !advance, $stable(crc_q), "CRC register moved without a byte")
	`CCRC_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && is_last_s1 && m_tvalid && !m_tready, "input stalled without output backpressure")

endmodule
